// File: rtl/dbrms_pkg.sv
// ----------------------------------------------------------------------------
// Debounced run-button mode sequencer package
// Shared types, register indexes, reset values and the deadline compare.
// ----------------------------------------------------------------------------
package dbrms_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned CODE_W      = 11;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_VERIFY_DELAY  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_HOLD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESET_CODE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED_CODE  = 3'd3;

  // Reset values of the configuration registers.
  localparam logic [DELAY_W-1:0] VERIFY_DELAY_RST = 16'd200;
  localparam logic [DELAY_W-1:0] RESET_HOLD_RST   = 16'd1000;
  localparam logic [CODE_W-1:0]  RESET_CODE_RST   = 11'd1811;
  localparam logic [CODE_W-1:0]  ENABLED_CODE_RST = 11'd1;

  typedef enum logic [1:0] {
    MODE_DISABLED   = 2'd0,
    MODE_POSE_RESET = 2'd1,
    MODE_ENABLED    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              button_level;
  } req_t;

  typedef struct packed {
    logic [1:0]        run_mode;
    logic              wants_enable;
    logic [CODE_W-1:0] user_code;
    logic              press_seen;
  } res_t;

  typedef struct packed {
    logic [DELAY_W-1:0] verify_delay_ms;
    logic [DELAY_W-1:0] reset_hold_ms;
    logic [CODE_W-1:0]  reset_user_code;
    logic [CODE_W-1:0]  enabled_user_code;
  } cfg_t;

  // True when now is strictly later than the deadline, within half the
  // timestamp range, so the compare survives counter wrap.
  function automatic logic deadline_passed(logic [TIME_W-1:0] now,
                                           logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = now - deadline;
    return (diff != '0) && !diff[TIME_W-1];
  endfunction

endpackage

// File: rtl/dbrms_engine.sv
// ----------------------------------------------------------------------------
// Debounced run-button mode sequencer engine
// Holds the mode and press-detector state and computes one update per request.
// ----------------------------------------------------------------------------
module dbrms_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  dbrms_pkg::req_t  req,
  input  dbrms_pkg::cfg_t  cfg,
  output dbrms_pkg::res_t  res
);

  dbrms_pkg::mode_t                    mode, mode_next;
  logic                                press_latched, press_latched_next;
  logic                                verifying, verifying_next;
  logic [dbrms_pkg::TIME_W-1:0]        verify_deadline, verify_deadline_next;
  logic [dbrms_pkg::TIME_W-1:0]        mode_deadline, mode_deadline_next;
  logic [dbrms_pkg::CODE_W-1:0]        user_value, user_value_next;

  // Press detector outcome, applied only in the disabled and enabled modes.
  logic                                det_latched, det_verifying, det_press;
  logic [dbrms_pkg::TIME_W-1:0]        det_deadline;
  logic                                pressed;

  assign pressed = !req.button_level;

  always_comb begin
    det_latched   = press_latched;
    det_verifying = verifying;
    det_deadline  = verify_deadline;
    det_press     = 1'b0;
    if (verifying) begin
      if (dbrms_pkg::deadline_passed(req.now_ms, verify_deadline)) begin
        det_verifying = 1'b0;
        det_latched   = pressed;
        det_press     = pressed;
      end
    end else if (pressed && !press_latched) begin
      det_verifying = 1'b1;
      det_deadline  = req.now_ms + {{(dbrms_pkg::TIME_W - dbrms_pkg::DELAY_W){1'b0}},
                                    cfg.verify_delay_ms};
    end else if (!pressed) begin
      det_latched = 1'b0;
    end
  end

  always_comb begin
    mode_next            = mode;
    press_latched_next   = press_latched;
    verifying_next       = verifying;
    verify_deadline_next = verify_deadline;
    mode_deadline_next   = mode_deadline;
    user_value_next      = user_value;
    res.press_seen       = 1'b0;
    unique case (mode)
      dbrms_pkg::MODE_ENABLED: begin
        user_value_next      = cfg.enabled_user_code;
        press_latched_next   = det_latched;
        verifying_next       = det_verifying;
        verify_deadline_next = det_deadline;
        res.press_seen       = det_press;
        if (det_press) begin
          mode_next = dbrms_pkg::MODE_DISABLED;
        end
      end
      dbrms_pkg::MODE_POSE_RESET: begin
        user_value_next = cfg.reset_user_code;
        if (dbrms_pkg::deadline_passed(req.now_ms, mode_deadline)) begin
          mode_next = dbrms_pkg::MODE_ENABLED;
        end
      end
      default: begin
        // Disabled mode, and the unused code that behaves the same way.
        press_latched_next   = det_latched;
        verifying_next       = det_verifying;
        verify_deadline_next = det_deadline;
        res.press_seen       = det_press;
        if (det_press) begin
          mode_next          = dbrms_pkg::MODE_POSE_RESET;
          mode_deadline_next = req.now_ms + {{(dbrms_pkg::TIME_W - dbrms_pkg::DELAY_W){1'b0}},
                                             cfg.reset_hold_ms};
        end else begin
          mode_next = dbrms_pkg::MODE_DISABLED;
        end
      end
    endcase
    res.run_mode     = mode_next;
    res.wants_enable = (mode_next == dbrms_pkg::MODE_ENABLED);
    res.user_code    = user_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= dbrms_pkg::MODE_DISABLED;
      press_latched   <= 1'b0;
      verifying       <= 1'b0;
      verify_deadline <= '0;
      mode_deadline   <= '0;
      user_value      <= '0;
    end else if (accept) begin
      mode            <= mode_next;
      press_latched   <= press_latched_next;
      verifying       <= verifying_next;
      verify_deadline <= verify_deadline_next;
      mode_deadline   <= mode_deadline_next;
      user_value      <= user_value_next;
    end
  end

endmodule

// File: rtl/debounced_button_run_mode_sequencer.sv
// ----------------------------------------------------------------------------
// Debounced run-button mode sequencer
// Debounces an active-low run button and steps through disabled, pose-reset
// and enabled modes, reporting the mode and user code after every update.
// ----------------------------------------------------------------------------
// Each request carries a millisecond timestamp and the raw button level, and
// produces exactly one result. A request is taken on every clock while the
// block is not stalling, and its result is registered in the output register
// (or the skid register while the output is held), so the sustained rate is
// one request per clock. That rate is set by the update loop in the engine:
// the mode and detector registers are read, two 32-bit adds and two wrap-safe
// deadline compares are done, and the new state is written back in the same
// cycle. A two-entry output buffer (output register plus skid register) lets
// a new request be accepted while a finished result is still waiting to be
// taken; the input stalls only when both entries are full. The configuration
// port is always ready and should only be written while the block is idle.
module debounced_button_run_mode_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  dbrms_pkg::req_t                   req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output dbrms_pkg::res_t                   res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dbrms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbrms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dbrms_pkg::cfg_t cfg;
  dbrms_pkg::res_t engine_res;
  dbrms_pkg::res_t skid;
  logic            skid_valid;
  logic            accept;
  logic            take;

  // Configuration registers. Writes to indexes past the last register are
  // simply dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.verify_delay_ms   <= dbrms_pkg::VERIFY_DELAY_RST;
      cfg.reset_hold_ms     <= dbrms_pkg::RESET_HOLD_RST;
      cfg.reset_user_code   <= dbrms_pkg::RESET_CODE_RST;
      cfg.enabled_user_code <= dbrms_pkg::ENABLED_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dbrms_pkg::CFG_VERIFY_DELAY: cfg.verify_delay_ms   <= cfg_data;
        dbrms_pkg::CFG_RESET_HOLD:   cfg.reset_hold_ms     <= cfg_data;
        dbrms_pkg::CFG_RESET_CODE:   cfg.reset_user_code   <= cfg_data[dbrms_pkg::CODE_W-1:0];
        dbrms_pkg::CFG_ENABLED_CODE: cfg.enabled_user_code <= cfg_data[dbrms_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // The input only stalls once the skid register is holding a result.
  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign take      = res_valid && !res_stall;

  dbrms_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cfg    (cfg),
    .res    (engine_res)
  );

  // Output register and skid register. When the output register frees up,
  // a parked result moves forward first; otherwise the fresh result loads
  // directly. A result that arrives while the output is held goes to skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !res_valid) begin
      if (skid_valid) begin
        res <= skid;
      end else if (accept) begin
        res <= engine_res;
      end
    end else if (accept) begin
      skid <= engine_res;
    end
  end

`ifndef SYNTHESIS
  // A parked result always sits behind a valid output.
  a_skid_behind_output : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid register holds a result while the output is empty");

  // A request taken while the output is held must land in the skid register.
  a_park_on_stall : assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res_stall) |=> skid_valid)
    else $error("result lost while the output was stalled");

  // The enable flag tracks the reported mode.
  a_enable_matches_mode : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.wants_enable == (res.run_mode == dbrms_pkg::MODE_ENABLED)))
    else $error("wants_enable disagrees with run_mode");

  // A confirmed press always leaves the block outside enabled mode.
  a_press_leaves_enabled : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.press_seen) |-> (res.run_mode != dbrms_pkg::MODE_ENABLED))
    else $error("confirmed press reported with enabled mode");

  // The output only ever reports one of the three named modes.
  a_mode_in_range : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.run_mode == dbrms_pkg::MODE_DISABLED) ||
                   (res.run_mode == dbrms_pkg::MODE_POSE_RESET) ||
                   (res.run_mode == dbrms_pkg::MODE_ENABLED)))
    else $error("unused mode code reported");
`endif

endmodule
